FILE: src/swf_pkg.sv
// Shared types and constants for the SLIP word framer.
package swf_pkg;

  localparam int BYTES_PER_WORD_DEFAULT = 4;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] SLIP_END     = 8'hC0;
  localparam logic [7:0] SLIP_ESC     = 8'hDB;
  localparam logic [7:0] SLIP_ESC_END = 8'hDC;
  localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

  typedef enum logic [1:0] {
    KIND_PLAIN   = 2'd0,
    KIND_ESC_END = 2'd1,
    KIND_ESC_ESC = 2'd2,
    KIND_FRAME   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } entry_t;

endpackage

FILE: src/swf_front.sv
// Front end: takes a word, splits it into bytes and classifies each one.
module swf_front import swf_pkg::*; #(
  parameter int BYTES_PER_WORD = BYTES_PER_WORD_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,
  output logic        push,
  output entry_t      push_entry,
  input  logic        full
);

  localparam int SW = 8 * BYTES_PER_WORD;
  localparam int CW = $clog2(BYTES_PER_WORD + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [SW-1:0] sreg;
  logic [63:0]   ext;
  logic [7:0]    top_byte;
  logic          accept;
  logic          last_push;

  assign ext       = {32'd0, s_tdata};
  assign top_byte  = sreg[SW-1 -: 8];
  assign push      = busy && !full;
  assign last_push = push && (cnt == '0);
  assign s_tready  = !busy || last_push;
  assign accept    = s_tvalid && s_tready;

  always_comb begin
    push_entry.data = top_byte;
    if (cnt == '0) begin
      push_entry.kind = KIND_FRAME;
    end else if (top_byte == SLIP_END) begin
      push_entry.kind = KIND_ESC_END;
    end else if (top_byte == SLIP_ESC) begin
      push_entry.kind = KIND_ESC_ESC;
    end else begin
      push_entry.kind = KIND_PLAIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      cnt  <= CW'(BYTES_PER_WORD);
    end else if (last_push) begin
      busy <= 1'b0;
    end else if (push) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sreg <= ext[SW-1:0];
    end else if (push) begin
      sreg <= sreg << 8;
    end
  end

endmodule

FILE: src/swf_queue.sv
// Short register queue of classified bytes between front and back end.
module swf_queue import swf_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output entry_t head,
  output logic   empty
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  entry_t        mem [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full  = (count == (AW+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

endmodule

FILE: src/swf_back.sv
// Back end: turns classified bytes into the escaped byte stream.
module swf_back import swf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  entry_t     head,
  input  logic       empty,
  output logic       pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic       m_tlast
);

  logic       load;
  logic       pend;
  logic [7:0] pend_byte;

  assign load = !m_tvalid || m_tready;
  assign pop  = load && !pend && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      pend     <= 1'b0;
    end else if (load) begin
      if (pend) begin
        m_tvalid <= 1'b1;
        pend     <= 1'b0;
      end else if (!empty) begin
        m_tvalid <= 1'b1;
        pend     <= (head.kind == KIND_ESC_END) || (head.kind == KIND_ESC_ESC);
      end else begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend) begin
        m_tdata <= pend_byte;
        m_tlast <= 1'b0;
      end else begin
        m_tlast <= 1'b0;
        case (head.kind)
          KIND_PLAIN: begin
            m_tdata <= head.data;
          end
          KIND_ESC_END: begin
            m_tdata   <= SLIP_ESC;
            pend_byte <= SLIP_ESC_END;
          end
          KIND_ESC_ESC: begin
            m_tdata   <= SLIP_ESC;
            pend_byte <= SLIP_ESC_ESC;
          end
          KIND_FRAME: begin
            m_tdata <= SLIP_END;
            m_tlast <= 1'b1;
          end
          default: begin
            m_tdata <= head.data;
          end
        endcase
      end
    end
  end

endmodule

FILE: src/slip_word_framer_core.sv
// SLIP word framer: splits each 32-bit word into BYTES_PER_WORD bytes, most
// significant first, escapes 0xC0 and 0xDB, and closes the frame with 0xC0
// flagged by tlast. The output emits one byte per cycle while m_tready is high
// and bytes are queued, which sets the sustained throughput. A word yields
// BYTES_PER_WORD + 1 to 2 * BYTES_PER_WORD + 1 output bytes (5 to 9 at the
// default). The front end classifies one byte per cycle into a four-entry
// queue unless it is full, and takes a new word when it queues the frame end.
module slip_word_framer_core import swf_pkg::*; #(
  parameter int BYTES_PER_WORD = BYTES_PER_WORD_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast
);

  logic   push;
  entry_t push_entry;
  logic   full;
  logic   pop;
  entry_t head;
  logic   empty;

  swf_front #(
    .BYTES_PER_WORD(BYTES_PER_WORD)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push       (push),
    .push_entry (push_entry),
    .full       (full)
  );

  swf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .empty      (empty)
  );

  swf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: bench/slip_word_framer_checker.sv
// Checker for the SLIP word framer: predicts the escaped byte stream and compares it.
module slip_word_framer_checker import swf_pkg::*; #(
  parameter int BYTES_PER_WORD = BYTES_PER_WORD_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] word
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // [7:0] out_byte
  input  logic        m_tlast,
  output int          error_count,
  output int          bytes_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } slip_byte_t;

  slip_byte_t slip_bytes [$];

  initial begin
    error_count = 0;
    bytes_due = 0;
  end

  // Splits one word into bytes, most significant first, and queues the
  // escaped stream followed by the flagged end byte.
  function automatic void frame_word(input logic [31:0] word);
    logic [7:0] b;
    int shift;
    for (int i = 0; i < BYTES_PER_WORD; i++) begin
      shift = 8 * (BYTES_PER_WORD - 1 - i);
      // Bytes above bit 31 come out as zero.
      b = 8'(word >> shift);
      if (b == SLIP_END) begin
        slip_bytes.push_back('{data: SLIP_ESC, last: 1'b0});
        slip_bytes.push_back('{data: SLIP_ESC_END, last: 1'b0});
      end else if (b == SLIP_ESC) begin
        slip_bytes.push_back('{data: SLIP_ESC, last: 1'b0});
        slip_bytes.push_back('{data: SLIP_ESC_ESC, last: 1'b0});
      end else begin
        slip_bytes.push_back('{data: b, last: 1'b0});
      end
    end
    slip_bytes.push_back('{data: SLIP_END, last: 1'b1});
  endfunction

  always @(posedge clk) begin
    slip_byte_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        frame_word(s_tdata);
      end
      if (m_tvalid && m_tready) begin
        if (slip_bytes.size() == 0) begin
          error_count++;
          if (error_count <= 10) begin
            $display("ERROR: unexpected output byte %02h last %0b", m_tdata, m_tlast);
          end
        end else begin
          want = slip_bytes.pop_front();
          if (m_tdata !== want.data || m_tlast !== want.last) begin
            error_count++;
            if (error_count <= 10) begin
              $display("ERROR: expected byte %02h last %0b, got byte %02h last %0b",
                       want.data, want.last, m_tdata, m_tlast);
            end
          end
        end
      end
    end
    bytes_due = slip_bytes.size();
  end

endmodule

FILE: bench/slip_word_framer_core_tb.sv
// Testbench top for the SLIP word framer: drives words, stalls the output and reports.
module slip_word_framer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_WORDS = 450;
  localparam int QUIET_FROM = 390;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  int error_count;
  int bytes_due;
  bit quiet = 1'b0;
  int stall_left = 0;
  int idle_cycles = 0;

  logic [31:0] directed_words [$] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'hC0C0_C0C0, 32'hDBDB_DBDB,
    32'hC0DB_C0DB, 32'hDBC0_DBC0, 32'h12C0_DB34, 32'h0000_00C0,
    32'hC000_0000, 32'h0000_00DB, 32'hDB00_0000, 32'hDCDD_DCDD,
    32'h8000_0001, 32'h7FFF_FFFE, 32'hC1DA_DCBF, 32'hBFC1_DADC
  };

  always #4 clk = ~clk;

  slip_word_framer_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  slip_word_framer_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .error_count (error_count),
    .bytes_due   (bytes_due)
  );

  // Output backpressure comes in bursts; none once the quiet phase starts.
  always @(posedge clk) begin
    if (stall_left > 0 && !quiet) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
      stall_left = 0;
      if (!quiet && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(1, 13);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("slip_word_framer_core test failed");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [31:0] word);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= word;
    do @(posedge clk); while (!s_tready);
  endtask

  initial begin
    logic [31:0] word;
    int pick;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_words[k]) begin
      send_word(directed_words[k]);
    end
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n >= QUIET_FROM) begin
        quiet = 1'b1;
      end
      if ($urandom_range(0, 4) == 0) begin
        word = $urandom;
      end else begin
        // Bias each byte toward the two escaped values and the escape codes DC and DD.
        for (int b = 0; b < 4; b++) begin
          pick = $urandom_range(0, 9);
          case (pick)
            0, 1: word[8*b +: 8] = 8'hC0;
            2, 3: word[8*b +: 8] = 8'hDB;
            4: word[8*b +: 8] = 8'hDC;
            5: word[8*b +: 8] = 8'hDD;
            default: word[8*b +: 8] = 8'($urandom);
          endcase
        end
      end
      send_word(word);
    end
    s_tvalid <= 1'b0;
    do @(negedge clk); while (bytes_due != 0);
    repeat (20) @(posedge clk);
    if (error_count == 0 && bytes_due == 0) begin
      $display("slip_word_framer_core test passed");
    end else begin
      $display("slip_word_framer_core test failed");
    end
    $finish;
  end

endmodule
